// File: rtl/ut2cal_pkg.sv
// Shared types, constants and tables for the Unix time to calendar converter.
// Used by every module of the block; depends on nothing else.
package ut2cal_pkg;

  // Field widths.
  localparam int unsigned TsW     = 32;
  localparam int unsigned TzW     = 5;
  localparam int unsigned DaysW   = 16;   // days since the epoch, below 49711
  localparam int unsigned SodW    = 17;   // seconds of the day, below 86400
  localparam int unsigned DoeW    = 18;   // day of the 400-year era
  localparam int unsigned YoeW    = 9;    // year of the era
  localparam int unsigned DoyW    = 9;    // day of the March-based year
  localparam int unsigned MinDayW = 11;   // minutes of the day, below 1440

  // Time and calendar constants.
  localparam int unsigned SecsPerHour  = 3600;
  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned DaySplitLow  = 7;                        // 86400 = 128 * 675
  localparam int unsigned DayDivisor   = SecsPerDay >> DaySplitLow;
  localparam int unsigned EpochShift   = 719468;
  localparam int unsigned DaysPerEra   = 146097;
  localparam int unsigned EraFourStart = 4 * DaysPerEra;
  localparam int unsigned EraFiveStart = 5 * DaysPerEra;
  localparam int unsigned DaysPer4Yr   = 1460;
  localparam int unsigned DaysPer100Yr = 36524;
  localparam int unsigned DaysPerYear  = 365;

  // The epoch falls in era 4; day 11017 after it starts era 5.
  localparam logic [DaysW-1:0] EraFiveDay   = DaysW'(EraFiveStart - EpochShift);
  localparam logic [DoeW-1:0]  EraFourDelta = DoeW'(EpochShift - EraFourStart);
  localparam logic [11:0]      EraFourYear  = 12'd1600;
  localparam logic [11:0]      EraFiveYear  = 12'd2000;

  // Reciprocals for division by constants: floor(2^S / D). With x below 2^S the
  // estimate floor(x * M / 2^S) is the true quotient or one less.
  localparam int unsigned DayDivShift = 25;
  localparam logic [15:0] DayRecip    = 16'((64'd1 << DayDivShift) / 64'(DayDivisor));
  localparam int unsigned SodDivShift = 17;
  localparam logic [11:0] SodRecip    = 12'((64'd1 << SodDivShift) / 64'd60);
  localparam int unsigned MinDivShift = 11;
  localparam logic [5:0]  MinRecip    = 6'((64'd1 << MinDivShift) / 64'd60);
  localparam int unsigned DoeDivShift = 18;
  localparam logic [7:0]  Recip1460   = 8'((64'd1 << DoeDivShift) / 64'(DaysPer4Yr));
  localparam logic [9:0]  Recip365    = 10'((64'd1 << DoeDivShift) / 64'(DaysPerYear));

  // First day of each month of a March-based year: (153 * mp + 2) / 5.
  localparam int unsigned MonthsPerYear = 12;
  localparam logic [DoyW-1:0] MonthStart [MonthsPerYear] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // Pipeline depths of the two parallel paths.
  localparam int unsigned DateLatency  = 8;
  localparam int unsigned ClockLatency = 4;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } ymd_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

endpackage

// File: rtl/unix_time_to_calendar.sv
// Top level of the Unix time to calendar converter.
// Depends on ut2cal_pkg, ut2cal_split, ut2cal_date and ut2cal_clock.
//
// A word on the start channel is a 32-bit Unix timestamp in seconds. It is
// taken at every rising edge at which start_i is high and busy_o is low. The
// converter is fully pipelined and never stalls, so busy_o stays low and a new
// word may be started in every cycle.
//
// Each word gives exactly one result word: year, month, day, hour, minute and
// second. The result sits on the output ports for one cycle, flagged by done_o.
// The split stages first apply the time-zone offset and split days from seconds
// (one reciprocal multiply and a correction), then the date path follows, which
// sets the latency. The time-of-day path is shorter and is padded to match.
// Throughput is one word per cycle; every stage holds at most one multiply by a
// constant.
//
// The time-zone offset is written on the cfg channel, which is always ready.
// It is a signed count of hours added modulo 2^32 before conversion. Write it
// only while no word is in flight. Reset clears the pipeline valid bits and
// sets the offset to zero. The receiver cannot hold results off.
module unix_time_to_calendar (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ut2cal_pkg::TsW-1:0]        unix_seconds_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [ut2cal_pkg::TzW-1:0] tz_offset_hours_i,
  output logic                              done_o,
  output logic [11:0]                       year_o,
  output logic [3:0]                        month_o,
  output logic [4:0]                        day_o,
  output logic [4:0]                        hour_o,
  output logic [5:0]                        minute_o,
  output logic [5:0]                        second_o
);
  import ut2cal_pkg::*;

  logic signed [TzW-1:0] tz_q;
  logic                  split_valid;
  logic [DaysW-1:0]      days;
  logic [SodW-1:0]       sod;
  ymd_t                  ymd;
  hms_t                  hms;

  // The pipeline never holds a word back.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tz_q <= tz_offset_hours_i;
    end
  end

  // Offset add and split into whole days and seconds of the day.
  ut2cal_split u_split (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (start_i && !busy_o),
    .unix_seconds_i    (unix_seconds_i),
    .tz_offset_hours_i (tz_q),
    .valid_o           (split_valid),
    .days_o            (days),
    .sod_o             (sod)
  );

  // Calendar date; its valid bit marks the finished result.
  ut2cal_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .days_i  (days),
    .valid_o (done_o),
    .ymd_o   (ymd)
  );

  // Time of day, delayed to arrive with the date.
  ut2cal_clock u_clock (
    .clk_i (clk_i),
    .sod_i (sod),
    .hms_o (hms)
  );

  assign year_o   = ymd.year;
  assign month_o  = ymd.month;
  assign day_o    = ymd.day;
  assign hour_o   = hms.hour;
  assign minute_o = hms.minute;
  assign second_o = hms.second;

endmodule

// File: rtl/ut2cal_split.sv
// Applies the time-zone offset and splits the timestamp into days and seconds.
// Depends on ut2cal_pkg.
module ut2cal_split (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [ut2cal_pkg::TsW-1:0]       unix_seconds_i,
  input  logic signed [ut2cal_pkg::TzW-1:0] tz_offset_hours_i,
  output logic                             valid_o,
  output logic [ut2cal_pkg::DaysW-1:0]     days_o,
  output logic [ut2cal_pkg::SodW-1:0]      sod_o
);
  import ut2cal_pkg::*;

  localparam int unsigned HiW = TsW - DaySplitLow;

  logic signed [16:0] shift;
  logic [TsW-1:0]     t_d, t_q;
  logic               v1_q, v2_q, v3_q;
  logic [HiW+15:0]    prod;
  logic [HiW-1:0]     hi_q;
  logic [DaySplitLow-1:0] lo_q;
  logic [DaysW-1:0]   est_q;
  logic [HiW-1:0]     rem_full;
  logic [10:0]        rem;
  logic [DaysW-1:0]   days_d, days_q;
  logic [SodW-1:0]    sod_d, sod_q;

  // Offset in seconds, sign-extended and added modulo 2^32.
  assign shift = 17'(tz_offset_hours_i) * 17'sd3600;
  assign t_d   = unix_seconds_i + TsW'(shift);

  assign prod = (HiW+16)'(t_q[TsW-1:DaySplitLow]) * (HiW+16)'(DayRecip);

  always_comb begin
    rem_full = hi_q - HiW'(est_q * 26'(DayDivisor));
    rem      = rem_full[10:0];
    days_d   = est_q;
    if (rem >= 11'(DayDivisor)) begin
      days_d = est_q + 1'b1;
      rem    = rem - 11'(DayDivisor);
    end
    sod_d = {rem[9:0], lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    est_q  <= prod[HiW+15:HiW];
    hi_q   <= t_q[TsW-1:DaySplitLow];
    lo_q   <= t_q[DaySplitLow-1:0];
    days_q <= days_d;
    sod_q  <= sod_d;
  end

  assign valid_o = v3_q;
  assign days_o  = days_q;
  assign sod_o   = sod_q;

endmodule

// File: rtl/ut2cal_clock.sv
// Converts the seconds of the day into hour, minute and second, then delays the
// word to line up with the date path. Depends on ut2cal_pkg.
module ut2cal_clock (
  input  logic                        clk_i,
  input  logic [ut2cal_pkg::SodW-1:0] sod_i,
  output ut2cal_pkg::hms_t            hms_o
);
  import ut2cal_pkg::*;

  localparam int unsigned PadDepth = DateLatency - ClockLatency;

  logic [SodW+11:0]    m_prod;
  logic [MinDayW-1:0]  m_est_q;
  logic [SodW-1:0]     sod1_q;
  logic [SodW-1:0]     s_rem;
  logic [MinDayW-1:0]  m_d, m_q;
  logic [5:0]          ss_d, ss_q, ss2_q;
  logic [MinDayW+5:0]  h_prod;
  logic [4:0]          h_est_q;
  logic [MinDayW-1:0]  m3_q;
  logic [MinDayW-1:0]  h_rem;
  logic [4:0]          hh_d;
  hms_t                hms_d, hms_q;
  hms_t                pad_q [PadDepth];

  assign m_prod = (SodW+12)'(sod_i) * (SodW+12)'(SodRecip);

  always_comb begin
    s_rem = sod1_q - SodW'(m_est_q * 17'd60);
    m_d   = m_est_q;
    if (s_rem >= SodW'(60)) begin
      m_d   = m_est_q + 1'b1;
      s_rem = s_rem - SodW'(60);
    end
    ss_d = s_rem[5:0];
  end

  assign h_prod = (MinDayW+6)'(m_q) * (MinDayW+6)'(MinRecip);

  always_comb begin
    h_rem = m3_q - MinDayW'(h_est_q * 11'd60);
    hh_d  = h_est_q;
    if (h_rem >= MinDayW'(60)) begin
      hh_d  = h_est_q + 1'b1;
      h_rem = h_rem - MinDayW'(60);
    end
    hms_d.hour   = hh_d;
    hms_d.minute = h_rem[5:0];
    hms_d.second = ss2_q;
  end

  always_ff @(posedge clk_i) begin
    m_est_q  <= m_prod[SodW+MinDayW-1:SodDivShift];
    sod1_q   <= sod_i;
    m_q      <= m_d;
    ss_q     <= ss_d;
    h_est_q  <= h_prod[MinDivShift+4:MinDivShift];
    m3_q     <= m_q;
    ss2_q    <= ss_q;
    hms_q    <= hms_d;
    pad_q[0] <= hms_q;
    for (int i = 1; i < PadDepth; i++) begin
      pad_q[i] <= pad_q[i-1];
    end
  end

  assign hms_o = pad_q[PadDepth-1];

endmodule

// File: rtl/ut2cal_date.sv
// Converts days since the epoch into Gregorian year, month and day by the
// era-based civil-from-days method. Depends on ut2cal_pkg.
module ut2cal_date (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ut2cal_pkg::DaysW-1:0] days_i,
  output logic                         valid_o,
  output ut2cal_pkg::ymd_t             ymd_o
);
  import ut2cal_pkg::*;

  logic [DateLatency-1:0] v_q;

  // Stage 1: day and number of the era.
  logic            era5_d, era5_q1, era5_q2, era5_q3, era5_q4, era5_q5;
  logic [DoeW-1:0] doe_d, doe_q1, doe_q2, doe_q3, doe_q4, doe_q5;
  // Stage 2: leap-cycle counts.
  logic [DoeW+7:0] a_prod;
  logic [7:0]      a_est_q;
  logic [2:0]      cent_cnt;
  logic [2:0]      bc_q;
  // Stage 3: days corrected for leap days.
  logic [DoeW-1:0] a_rem;
  logic [7:0]      a_fix;
  logic [DoeW-1:0] yden_d, yden_q, yden_q4;
  // Stage 4 and 5: year of the era.
  logic [DoeW+9:0] y_prod;
  logic [YoeW-1:0] yoe_est_q;
  logic [DoeW-1:0] y_rem;
  logic [YoeW-1:0] yoe_d, yoe_q;
  // Stage 6: day of the year and full year.
  logic [1:0]      yoe_cent;
  logic [DoeW-1:0] year_days;
  logic [DoeW-1:0] doy_full;
  logic [DoyW-1:0] doy_q6, doy_q7;
  logic [11:0]     yr_q6, yr_q7;
  // Stage 7: month index.
  logic [3:0]      mp_d, mp_q;
  // Stage 8: output word.
  ymd_t            ymd_d, ymd_q;
  logic [3:0]      mo;

  always_comb begin
    era5_d = (days_i >= EraFiveDay);
    if (era5_d) begin
      doe_d = DoeW'(days_i - EraFiveDay);
    end else begin
      doe_d = DoeW'(days_i) + EraFourDelta;
    end
  end

  assign a_prod = (DoeW+8)'(doe_q1) * (DoeW+8)'(Recip1460);

  always_comb begin
    cent_cnt = 3'(doe_q1 >= DoeW'(DaysPer100Yr))
             + 3'(doe_q1 >= DoeW'(2 * DaysPer100Yr))
             + 3'(doe_q1 >= DoeW'(3 * DaysPer100Yr))
             + 3'(doe_q1 >= DoeW'(4 * DaysPer100Yr));
  end

  always_comb begin
    a_rem = doe_q2 - DoeW'(a_est_q * 19'(DaysPer4Yr));
    a_fix = a_est_q;
    if (a_rem >= DoeW'(DaysPer4Yr)) begin
      a_fix = a_est_q + 1'b1;
    end
    yden_d = doe_q2 - DoeW'(a_fix) + DoeW'(bc_q);
  end

  assign y_prod = (DoeW+10)'(yden_q) * (DoeW+10)'(Recip365);

  always_comb begin
    y_rem = yden_q4 - DoeW'(yoe_est_q * 18'(DaysPerYear));
    yoe_d = yoe_est_q;
    if (y_rem >= DoeW'(DaysPerYear)) begin
      yoe_d = yoe_est_q + 1'b1;
    end
  end

  always_comb begin
    yoe_cent  = 2'(yoe_q >= YoeW'(100)) + 2'(yoe_q >= YoeW'(200)) + 2'(yoe_q >= YoeW'(300));
    year_days = DoeW'(yoe_q * 18'(DaysPerYear)) + DoeW'(yoe_q >> 2) - DoeW'(yoe_cent);
    doy_full  = doe_q5 - year_days;
  end

  always_comb begin
    mp_d = '0;
    for (int k = 1; k < MonthsPerYear; k++) begin
      mp_d = mp_d + 4'(doy_q6 >= MonthStart[k]);
    end
  end

  always_comb begin
    if (mp_q < 4'd10) begin
      mo = mp_q + 4'd3;
    end else begin
      mo = mp_q - 4'd9;
    end
    ymd_d.month = mo;
    ymd_d.day   = 5'(doy_q7 - MonthStart[mp_q] + 1'b1);
    ymd_d.year  = yr_q7 + 12'(mo <= 4'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DateLatency-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    era5_q1   <= era5_d;
    doe_q1    <= doe_d;
    a_est_q   <= a_prod[DoeDivShift+7:DoeDivShift];
    bc_q      <= cent_cnt - 3'(doe_q1 == DoeW'(DaysPerEra - 1));
    era5_q2   <= era5_q1;
    doe_q2    <= doe_q1;
    yden_q    <= yden_d;
    era5_q3   <= era5_q2;
    doe_q3    <= doe_q2;
    yoe_est_q <= y_prod[DoeDivShift+YoeW-1:DoeDivShift];
    yden_q4   <= yden_q;
    era5_q4   <= era5_q3;
    doe_q4    <= doe_q3;
    yoe_q     <= yoe_d;
    era5_q5   <= era5_q4;
    doe_q5    <= doe_q4;
    doy_q6    <= doy_full[DoyW-1:0];
    yr_q6     <= 12'(yoe_q) + (era5_q5 ? EraFiveYear : EraFourYear);
    mp_q      <= mp_d;
    doy_q7    <= doy_q6;
    yr_q7     <= yr_q6;
    ymd_q     <= ymd_d;
  end

  assign valid_o = v_q[DateLatency-1];
  assign ymd_o   = ymd_q;

endmodule
